// ----- src/indexed_array_list_macros.svh -----
// Assertion macros for the indexed array list block.
// Included by the top level; no other dependencies.
`ifndef INDEXED_ARRAY_LIST_MACROS_SVH
`define INDEXED_ARRAY_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define IAL_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("indexed_array_list: implication check failed");

// Next-cycle implication, checked outside reset
`define IAL_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("indexed_array_list: next-cycle check failed");

`else

`define IAL_ASSERT_IMP(name, clk, rstn, ante, cons)
`define IAL_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ----- src/ial_pkg.sv -----
// Shared types and constants for the indexed array list.
// No dependencies.
`timescale 1ns / 1ps

package ial_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 5;
    localparam int CNT_OUT_W = 5;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_POP    = 3'd2,
        FN_REMOVE = 3'd3,
        FN_READ   = 3'd4
    } func_e_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic ins;   // write at pos, cells above take their lower neighbor
        logic del;   // cells at and above pos take their upper neighbor
        logic rd;    // cell at pos drives its data onto the read bus
    } cell_ctrl_t;

endpackage

// ----- src/ial_cell.sv -----
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on ial_pkg.
`timescale 1ns / 1ps

module ial_cell
    import ial_pkg::*;
#(
    parameter int K     = 0,
    parameter int POS_W = 5
) (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]  pos,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [DATA_W-1:0] lower_data,
    input  logic [DATA_W-1:0] upper_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(K);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Next entry: new item, shift up, shift down or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins && (pos == MY_POS))
        begin
            data_next = wr_data;
        end
        else if (ctrl.ins && (MY_POS > pos))
        begin
            data_next = lower_data;
        end
        else if (ctrl.del && (MY_POS >= pos))
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Gated tap onto the shared read bus
    assign rd_data = (ctrl.rd && (pos == MY_POS)) ? data_reg : '0;

endmodule

// ----- src/indexed_array_list.sv -----
// Indexed array list: bounded ordered list of signed 32-bit values.
// Command channel: start/busy with func, index and value. An operation is
// transferred on a rising edge with start high and busy low. busy is always
// low, so a new command may be given every cycle.
// Result channel: result_value, ok, count and empty_res are shown for
// exactly one cycle with done high, the cycle after the command transfer
// (throughput 1 operation per cycle). The receiver cannot stall;
// the result must be taken in that cycle.
// Storage is a chain of DEPTH cells, one entry each. Insert and remove shift
// all cells above the position in the same clock; reads come from a gated
// OR bus across the cells, registered into the result.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// result; cell contents are not cleared since only entries below the count
// are ever read.
// Failing operations (full list, empty pop, bad index, unused codes) return
// ok low, zero value and the unchanged count.
// Depends on ial_pkg, ial_cell and indexed_array_list_macros.svh.
`timescale 1ns / 1ps
`include "indexed_array_list_macros.svh"

module indexed_array_list
    import ial_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [FUNC_W-1:0]           func,
    input  logic [IDX_W-1:0]            index,
    input  logic signed [DATA_W-1:0]    value,
    output logic                        done,
    output logic signed [DATA_W-1:0]    result_value,
    output logic                        ok,
    output logic [CNT_OUT_W-1:0]        count,
    output logic                        empty_res
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CMPW-1:0] FULL_CNT = CMPW'(DEPTH);

    logic                accept;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CMPW-1:0]     cnt_x;
    logic [CMPW-1:0]     idx_x;
    logic [CMPW-1:0]     pos;
    logic                op_ok;
    cell_ctrl_t          ctrl;
    logic [DATA_W-1:0]   rd_bus;

    logic                done_reg;
    logic [DATA_W-1:0]   res_value_reg;
    logic                ok_reg;
    logic [CNT_OUT_W-1:0] count_reg;
    logic                empty_reg;

    logic [DATA_W-1:0]   cell_q [DEPTH];
    logic [DATA_W-1:0]   cell_rd [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cnt_x  = CMPW'(cnt_reg);
    assign idx_x  = CMPW'(index);

    // Decode the command into cell control and the new count
    always_comb
    begin
        op_ok    = 1'b0;
        pos      = idx_x;
        ctrl     = '0;
        cnt_next = cnt_reg;
        case (func_e_t'(func))
            FN_APPEND:
            begin
                op_ok    = (cnt_x != FULL_CNT);
                pos      = cnt_x;
                ctrl.ins = op_ok;
                if (op_ok)
                    cnt_next = cnt_reg + CW'(1);
            end
            FN_INSERT:
            begin
                op_ok    = (cnt_x != FULL_CNT) && (idx_x <= cnt_x);
                ctrl.ins = op_ok;
                if (op_ok)
                    cnt_next = cnt_reg + CW'(1);
            end
            FN_POP:
            begin
                op_ok   = (cnt_x != '0);
                pos     = cnt_x - CMPW'(1);
                ctrl.rd = op_ok;
                if (op_ok)
                    cnt_next = cnt_reg - CW'(1);
            end
            FN_REMOVE:
            begin
                op_ok    = (idx_x < cnt_x);
                ctrl.rd  = op_ok;
                ctrl.del = op_ok;
                if (op_ok)
                    cnt_next = cnt_reg - CW'(1);
            end
            FN_READ:
            begin
                op_ok   = (idx_x < cnt_x);
                ctrl.rd = op_ok;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
        if (!accept)
        begin
            ctrl     = '0;
            cnt_next = cnt_reg;
        end
    end

    // Chain of storage cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_q[g+1];
        end

        ial_cell #(
            .K     (g),
            .POS_W (CMPW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos),
            .wr_data    (value),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_q[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // Read bus: at most one cell drives a nonzero tap
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= accept;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_value_reg <= rd_bus;
            ok_reg        <= op_ok;
            count_reg     <= CNT_OUT_W'(cnt_next);
            empty_reg     <= (cnt_next == '0);
        end
    end

    assign done         = done_reg;
    assign result_value = $signed(res_value_reg);
    assign ok           = ok_reg;
    assign count        = count_reg;
    assign empty_res    = empty_reg;

    // Checks
    `IAL_ASSERT_IMP(a_empty_flag, clk, rst_n, done, empty_res == (count == '0))
    `IAL_ASSERT_IMP(a_fail_zero, clk, rst_n, done && !ok, result_value == '0)
    `IAL_ASSERT_NXT(a_fail_hold, clk, rst_n, accept && !op_ok, cnt_reg == $past(cnt_reg))
    `IAL_ASSERT_NXT(a_ins_grow, clk, rst_n, ctrl.ins, cnt_reg == $past(cnt_reg) + CW'(1))

endmodule

// ----- verif/ial_list_checker.sv -----
// Checker for the indexed array list: predicts each operation and compares results.
// Watches the command and result channels; uses types and widths from ial_pkg.
`timescale 1ns / 1ps

module ial_list_checker
    import ial_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [FUNC_W-1:0]        func,
    input  logic [IDX_W-1:0]         index,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] result_value,
    input  logic                     ok,
    input  logic [CNT_OUT_W-1:0]     count,
    input  logic                     empty_res,
    output int                       fail_count,
    output int                       pending,
    output int                       checked_count,
    output int                       full_hits,
    output int                       reject_count
);

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic                     ok;
        logic [CNT_OUT_W-1:0]     len;
        logic                     empty;
    } list_result_t;

    // Predicted list contents and length
    logic signed [DATA_W-1:0] list_mem [DEPTH_DEF];
    int                       list_len;
    list_result_t             expected_results [$];

    int errors;
    int checked;
    int fulls;
    int rejects;

    assign fail_count    = errors;
    assign checked_count = checked;
    assign full_hits     = fulls;
    assign reject_count  = rejects;

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        errors++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    endtask

    // One list operation on the predicted state; returns the expected result
    task automatic apply_list_op(
        input  logic [FUNC_W-1:0]        op,
        input  logic [IDX_W-1:0]         pos,
        input  logic signed [DATA_W-1:0] din,
        output list_result_t             res
    );
        int k;
        res.data = '0;
        res.ok   = 1'b0;
        case (op)
            FN_APPEND:
            begin
                if (list_len < DEPTH_DEF)
                begin
                    list_mem[list_len] = din;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            FN_INSERT:
            begin
                if (list_len < DEPTH_DEF && int'(pos) <= list_len)
                begin
                    for (k = list_len; k > int'(pos); k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos] = din;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            FN_POP:
            begin
                if (list_len > 0)
                begin
                    list_len--;
                    res.data = list_mem[list_len];
                    res.ok   = 1'b1;
                end
            end
            FN_REMOVE:
            begin
                if (int'(pos) < list_len)
                begin
                    res.data = list_mem[pos];
                    for (k = int'(pos); k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            FN_READ:
            begin
                if (int'(pos) < list_len)
                begin
                    res.data = list_mem[pos];
                    res.ok   = 1'b1;
                end
            end
            default: ;  // spare codes: no effect
        endcase
        res.len   = list_len[CNT_OUT_W-1:0];
        res.empty = (list_len == 0);
        if (!res.ok)
            rejects++;
        if ((op == FN_APPEND || op == FN_INSERT) && list_len == DEPTH_DEF)
            fulls++;
    endtask

    // Compare results against the oldest expectation, then predict new transfers
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        list_result_t new_r;
        if (!rst_n)
        begin
            expected_results.delete();
            list_len = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", 0, 1);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (result_value !== exp_r.data)
                        report_mismatch("result_value", longint'(exp_r.data),
                                        longint'(result_value));
                    if (ok !== exp_r.ok)
                        report_mismatch("ok", longint'(exp_r.ok), longint'(ok));
                    if (count !== exp_r.len)
                        report_mismatch("count", longint'(exp_r.len), longint'(count));
                    if (empty_res !== exp_r.empty)
                        report_mismatch("empty_res", longint'(exp_r.empty),
                                        longint'(empty_res));
                end
            end
            if (start && !busy)
            begin
                apply_list_op(func, index, value, new_r);
                expected_results.push_back(new_r);
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ----- verif/tb_indexed_array_list.sv -----
// Testbench top for the indexed array list: directed and random list operations.
// Depends on ial_pkg, the indexed_array_list RTL and ial_list_checker.
`timescale 1ns / 1ps

module tb_indexed_array_list;
    import ial_pkg::*;

    localparam int RANDOM_OPS = 1450;

    // Spare operation codes that must do nothing
    localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Stimulus mix of one random phase
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE } phase_mix_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [FUNC_W-1:0]        func = '0;
    logic [IDX_W-1:0]         index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic signed [DATA_W-1:0] result_value;
    logic                     ok;
    logic [CNT_OUT_W-1:0]     count;
    logic                     empty_res;

    int fail_count;
    int pending;
    int checked_count;
    int full_hits;
    int reject_count;

    int  issued;
    bit  gaps_on;
    int  last_len = 0;

    indexed_array_list #(.DEPTH(DEPTH_DEF)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .index        (index),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .ok           (ok),
        .count        (count),
        .empty_res    (empty_res)
    );

    ial_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .index         (index),
        .value         (value),
        .done          (done),
        .result_value  (result_value),
        .ok            (ok),
        .count         (count),
        .empty_res     (empty_res),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .full_hits     (full_hits),
        .reject_count  (reject_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Last reported length, used only to steer indices toward valid positions
    always @(posedge clk)
    begin
        if (done)
            last_len <= int'(count);
    end

    // One command transfer, with an optional idle gap first
    task automatic send_op(
        input logic [FUNC_W-1:0]        op,
        input logic [IDX_W-1:0]         pos,
        input logic signed [DATA_W-1:0] din
    );
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func  <= op;
        index <= pos;
        value <= din;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input bit for_insert);
        int hi;
        hi = for_insert ? last_len : ((last_len > 0) ? last_len - 1 : 0);
        if ($urandom_range(0, 9) < 8)
            return IDX_W'($urandom_range(0, hi));
        return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endfunction

    // One random operation shaped by the phase mix
    task automatic send_random(input phase_mix_t mix);
        int r;
        logic [FUNC_W-1:0] op;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     op = (r < 45) ? FN_APPEND : (r < 85) ? FN_INSERT :
                               (r < 93) ? FN_READ : (r < 97) ? FN_REMOVE : FN_POP;
            MIX_DRAIN:    op = (r < 35) ? FN_POP : (r < 75) ? FN_REMOVE :
                               (r < 90) ? FN_READ : (r < 95) ? FN_APPEND : FN_INSERT;
            MIX_BALANCED: op = (r < 20) ? FN_APPEND : (r < 40) ? FN_INSERT :
                               (r < 55) ? FN_POP : (r < 75) ? FN_REMOVE : FN_READ;
            default:      op = FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1));
        endcase
        if (mix == MIX_NOISE)
            send_op(op, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)), $urandom);
        else
            send_op(op, pick_index(op == FN_INSERT), pick_value());
    endtask

    // Main stimulus
    initial
    begin
        int         phase_len;
        phase_mix_t mix;
        bit         first_phase;

        issued      = 0;
        gaps_on     = 1'b1;
        first_phase = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list failures, extremes, shifts, bad indices, spare codes
        send_op(FN_POP,    5'd0,  '0);
        send_op(FN_READ,   5'd0,  '0);
        send_op(FN_REMOVE, 5'd0,  '0);
        send_op(FN_INSERT, 5'd1,  32'sd5);
        send_op(FN_INSERT, 5'd0,  VAL_MIN);
        send_op(FN_APPEND, 5'd31, VAL_MAX);
        send_op(FN_APPEND, 5'd0,  '0);
        send_op(FN_INSERT, 5'd1,  -1);
        send_op(FN_INSERT, 5'd4,  32'sh5A5A_A5A5);
        send_op(FN_READ,   5'd0,  '0);
        send_op(FN_READ,   5'd4,  '0);
        send_op(FN_READ,   5'd5,  '0);
        send_op(FN_INSERT, 5'd6,  32'sd7);
        send_op(FN_REMOVE, 5'd1,  '0);
        send_op(FN_REMOVE, 5'd31, '0);
        send_op(FN_READ,   5'd16, '0);
        send_op(FN_SPARE_5, 5'd0, -1);
        send_op(FN_SPARE_6, 5'd1, VAL_MAX);
        send_op(FN_SPARE_7, 5'd31, VAL_MIN);
        send_op(FN_POP,    5'd0,  '0);
        send_op(FN_REMOVE, 5'd0,  '0);
        send_op(FN_POP,    5'd0,  '0);
        send_op(FN_POP,    5'd0,  '0);
        send_op(FN_READ,   5'd0,  '0);

        // Random phases: mostly fill/drain cycles, some balanced and noise
        while (issued < RANDOM_OPS + 24)
        begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 9))
                0, 1, 2: mix = MIX_FILL;
                3, 4, 5: mix = MIX_DRAIN;
                6, 7, 8: mix = MIX_BALANCED;
                default: mix = MIX_NOISE;
            endcase
            if (first_phase)
                mix = MIX_FILL;
            first_phase = 1'b0;
            gaps_on = ($urandom_range(0, 2) != 0);
            repeat (phase_len)
                send_random(mix);
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d list operations, %0d results checked.", issued, checked_count);
        $display("List reached capacity %0d times; %0d operations were rejected.",
                 full_hits, reject_count);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_indexed_array_list passed");
        else
            $display("tb_indexed_array_list failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Run limit reached with %0d results outstanding", pending);
        $display("tb_indexed_array_list failed");
        $finish;
    end

endmodule
